[rtl/assert_macros.svh]
// Assertion helpers used by the core RTL. Both macros expect clk in scope; AAT_ASSERT also uses rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define AAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset cycles included.
`define AAT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/aat_pkg.sv]
package aat_pkg;

  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned NUM_ROWS = 3;
  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned NUM_COEF = NUM_ROWS * NUM_AXES;
  localparam int unsigned NUM_REGS = 6;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned REG_W    = 64;
  localparam int unsigned BOX_W    = 2 * NUM_AXES * FIELD_W;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_X_PAIR  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_X_THIRD = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_Y_PAIR  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_Y_THIRD = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_Z_PAIR  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_Z_THIRD = 3'd5;

  localparam logic [REG_IDX_W-1:0] ROW_PAIR_REG  [NUM_ROWS] =
    '{REG_X_PAIR, REG_Y_PAIR, REG_Z_PAIR};
  localparam logic [REG_IDX_W-1:0] ROW_THIRD_REG [NUM_ROWS] =
    '{REG_X_THIRD, REG_Y_THIRD, REG_Z_THIRD};

  // Identity map, zero translation.
  localparam logic [REG_W-1:0] CFG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000,
    64'h0, 64'h0, 64'h0000_0000_0001_0000
  };

  // Load enables of the two adder ranks.
  typedef struct packed {
    logic sum_a;
    logic sum_b;
  } add_en_t;

endpackage

[rtl/aat_opsel.sv]
module aat_opsel #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] coef   [aat_pkg::NUM_COEF],
  input  logic signed [COORD_BITS-1:0] lo_in  [aat_pkg::NUM_AXES],
  input  logic signed [COORD_BITS-1:0] hi_in  [aat_pkg::NUM_AXES],
  output logic signed [COORD_BITS-1:0] lo_op  [aat_pkg::NUM_COEF],
  output logic signed [COORD_BITS-1:0] hi_op  [aat_pkg::NUM_COEF]
);
  import aat_pkg::*;

  // Positive coefficient keeps the same-side bound, otherwise swap.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          if (!coef[r*NUM_AXES+i][COORD_BITS-1] && (coef[r*NUM_AXES+i] != '0)) begin
            lo_op[r*NUM_AXES+i] <= lo_in[i];
            hi_op[r*NUM_AXES+i] <= hi_in[i];
          end else begin
            lo_op[r*NUM_AXES+i] <= hi_in[i];
            hi_op[r*NUM_AXES+i] <= lo_in[i];
          end
        end
      end
    end
  end

endmodule

[rtl/aat_mul.sv]
module aat_mul #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [COORD_BITS-1:0]   coef  [aat_pkg::NUM_COEF],
  input  logic signed [COORD_BITS-1:0]   lo_op [aat_pkg::NUM_COEF],
  input  logic signed [COORD_BITS-1:0]   hi_op [aat_pkg::NUM_COEF],
  output logic signed [2*COORD_BITS-1:0] p_lo  [aat_pkg::NUM_COEF],
  output logic signed [2*COORD_BITS-1:0] p_hi  [aat_pkg::NUM_COEF]
);
  import aat_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NUM_COEF; j++) begin
        p_lo[j] <= coef[j] * lo_op[j];
        p_hi[j] <= coef[j] * hi_op[j];
      end
    end
  end

endmodule

[rtl/aat_add_tree.sv]
module aat_add_tree #(
  parameter int unsigned COORD_BITS    = 32,
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned SUM_W         = 66
) (
  input  logic                           clk,
  input  aat_pkg::add_en_t               en,
  input  logic signed [2*COORD_BITS-1:0] p_lo   [aat_pkg::NUM_COEF],
  input  logic signed [2*COORD_BITS-1:0] p_hi   [aat_pkg::NUM_COEF],
  input  logic signed [COORD_BITS-1:0]   trans  [aat_pkg::NUM_ROWS],
  output logic signed [SUM_W-1:0]        sum_lo [aat_pkg::NUM_ROWS],
  output logic signed [SUM_W-1:0]        sum_hi [aat_pkg::NUM_ROWS]
);
  import aat_pkg::*;

  logic signed [SUM_W-1:0] a_lo [NUM_ROWS];
  logic signed [SUM_W-1:0] a_hi [NUM_ROWS];
  logic signed [SUM_W-1:0] b_lo [NUM_ROWS];
  logic signed [SUM_W-1:0] b_hi [NUM_ROWS];
  logic signed [SUM_W-1:0] t_sc [NUM_ROWS];

  // Translation aligned to the product scale.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      t_sc[r] = SUM_W'(trans[r]) <<< FRACTION_BITS;
    end
  end

  // First rank: x+y terms, z term plus translation.
  always_ff @(posedge clk) begin
    if (en.sum_a) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        a_lo[r] <= SUM_W'(p_lo[r*NUM_AXES]) + SUM_W'(p_lo[r*NUM_AXES+1]);
        a_hi[r] <= SUM_W'(p_hi[r*NUM_AXES]) + SUM_W'(p_hi[r*NUM_AXES+1]);
        b_lo[r] <= SUM_W'(p_lo[r*NUM_AXES+2]) + t_sc[r];
        b_hi[r] <= SUM_W'(p_hi[r*NUM_AXES+2]) + t_sc[r];
      end
    end
  end

  // Second rank: combine.
  always_ff @(posedge clk) begin
    if (en.sum_b) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        sum_lo[r] <= a_lo[r] + b_lo[r];
        sum_hi[r] <= a_hi[r] + b_hi[r];
      end
    end
  end

endmodule

[rtl/aat_sat.sv]
module aat_sat #(
  parameter int unsigned COORD_BITS    = 32,
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned SUM_W         = 66
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [SUM_W-1:0]      sum_lo [aat_pkg::NUM_ROWS],
  input  logic signed [SUM_W-1:0]      sum_hi [aat_pkg::NUM_ROWS],
  output logic [aat_pkg::FIELD_W-1:0]  out_lo [aat_pkg::NUM_ROWS],
  output logic [aat_pkg::FIELD_W-1:0]  out_hi [aat_pkg::NUM_ROWS]
);
  import aat_pkg::*;

  localparam logic signed [SUM_W-1:0] CMAX =
    signed'({{(SUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] CMIN = ~CMAX;

  logic signed [SUM_W-1:0] sh_lo  [NUM_ROWS];
  logic signed [SUM_W-1:0] sh_hi  [NUM_ROWS];
  logic signed [SUM_W-1:0] cl_lo  [NUM_ROWS];
  logic signed [SUM_W-1:0] cl_hi  [NUM_ROWS];

  // Floor shift back to coordinate scale, then clamp to the coordinate range.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      sh_lo[r] = sum_lo[r] >>> FRACTION_BITS;
      sh_hi[r] = sum_hi[r] >>> FRACTION_BITS;
      if (sh_lo[r] > CMAX)      cl_lo[r] = CMAX;
      else if (sh_lo[r] < CMIN) cl_lo[r] = CMIN;
      else                      cl_lo[r] = sh_lo[r];
      if (sh_hi[r] > CMAX)      cl_hi[r] = CMAX;
      else if (sh_hi[r] < CMIN) cl_hi[r] = CMIN;
      else                      cl_hi[r] = sh_hi[r];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        out_lo[r] <= FIELD_W'(signed'(cl_lo[r][COORD_BITS-1:0]));
        out_hi[r] <= FIELD_W'(signed'(cl_hi[r][COORD_BITS-1:0]));
      end
    end
  end

endmodule

[rtl/aabb_affine_transform_core.sv]
// Affine box transform: each word on in_tdata is an axis-aligned box
// (lower and upper bound per axis, signed fixed point with FRACTION_BITS
// fraction bits) and each word on out_tdata is the axis-aligned box that
// bounds its image under out = M * in + t, with M and t taken from the six
// configuration registers (identity and zero translation after reset).
// For every coefficient the sign picks which input bound feeds the lower and
// which the upper output bound. Sums are exact, floored back to coordinate
// scale and saturated to the signed COORD_BITS range, sign-extended to 32 bits.
// Throughput is one box per clock unless a stall on out_tready fills the pipe,
// set by the 18 parallel multipliers. The pipe has five register stages
// (operand select, multiply, two adder ranks, floor/saturate), passed in that
// order; out_tvalid is the last stage's valid. Stalls on out_tready back up
// stage by stage, so bubbles in the pipe still let new boxes in. Write the
// registers only while the pipe is empty; cfg_ready is always high.
`include "assert_macros.svh"

module aabb_affine_transform_core #(
  parameter int unsigned COORD_BITS    = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // in_tdata, low bit up: in_low_x, in_low_y, in_low_z,
  //                       in_high_x, in_high_y, in_high_z (32 bits each)
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [aat_pkg::BOX_W-1:0]      in_tdata,
  // out_tdata, low bit up: out_low_x, out_low_y, out_low_z,
  //                        out_high_x, out_high_y, out_high_z (32 bits each)
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [aat_pkg::BOX_W-1:0]      out_tdata,
  // Register write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [aat_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [aat_pkg::REG_W-1:0]      cfg_data
);
  import aat_pkg::*;

  localparam int unsigned PROD_W = 2 * COORD_BITS;
  localparam int unsigned TSC_W  = COORD_BITS + FRACTION_BITS;
  localparam int unsigned SUM_W  = ((PROD_W > TSC_W) ? PROD_W : TSC_W) + 2;
  localparam int unsigned STAGES = 5;

  logic [REG_W-1:0] cfg_reg [NUM_REGS];

  logic signed [COORD_BITS-1:0] coef  [NUM_COEF];
  logic signed [COORD_BITS-1:0] trans [NUM_ROWS];
  logic signed [COORD_BITS-1:0] lo_in [NUM_AXES];
  logic signed [COORD_BITS-1:0] hi_in [NUM_AXES];
  logic signed [COORD_BITS-1:0] lo_op [NUM_COEF];
  logic signed [COORD_BITS-1:0] hi_op [NUM_COEF];
  logic signed [PROD_W-1:0]     p_lo  [NUM_COEF];
  logic signed [PROD_W-1:0]     p_hi  [NUM_COEF];
  logic signed [SUM_W-1:0]      sum_lo [NUM_ROWS];
  logic signed [SUM_W-1:0]      sum_hi [NUM_ROWS];
  logic [FIELD_W-1:0]           out_lo [NUM_ROWS];
  logic [FIELD_W-1:0]           out_hi [NUM_ROWS];

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] rdy;
  add_en_t           add_en;

  // ---------------------------------------------------------------------------
  // Configuration registers; indexes past the list are dropped.
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_REGS; k++) cfg_reg[k] <= CFG_RESET[k];
    end else if (cfg_valid && (cfg_index < REG_IDX_W'(NUM_REGS))) begin
      cfg_reg[cfg_index] <= cfg_data;
    end
  end

  // Coefficients and translation use the low COORD_BITS of each 32-bit half.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      coef[r*NUM_AXES]   = signed'(cfg_reg[ROW_PAIR_REG[r]][COORD_BITS-1:0]);
      coef[r*NUM_AXES+1] = signed'(cfg_reg[ROW_PAIR_REG[r]][FIELD_W +: COORD_BITS]);
      coef[r*NUM_AXES+2] = signed'(cfg_reg[ROW_THIRD_REG[r]][COORD_BITS-1:0]);
      trans[r]           = signed'(cfg_reg[ROW_THIRD_REG[r]][FIELD_W +: COORD_BITS]);
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      lo_in[i] = signed'(in_tdata[i*FIELD_W +: COORD_BITS]);
      hi_in[i] = signed'(in_tdata[(NUM_AXES+i)*FIELD_W +: COORD_BITS]);
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its successor loads.
  // ---------------------------------------------------------------------------
  always_comb begin
    rdy[STAGES-1] = !vld[STAGES-1] || out_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_tready    = rdy[0];
  assign out_tvalid   = vld[STAGES-1];
  assign add_en.sum_a = rdy[2];
  assign add_en.sum_b = rdy[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_tvalid;
      for (int k = 1; k < STAGES; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  aat_opsel #(.COORD_BITS(COORD_BITS)) u_opsel (
    .clk   (clk),
    .en    (rdy[0]),
    .coef  (coef),
    .lo_in (lo_in),
    .hi_in (hi_in),
    .lo_op (lo_op),
    .hi_op (hi_op)
  );

  aat_mul #(.COORD_BITS(COORD_BITS)) u_mul (
    .clk   (clk),
    .en    (rdy[1]),
    .coef  (coef),
    .lo_op (lo_op),
    .hi_op (hi_op),
    .p_lo  (p_lo),
    .p_hi  (p_hi)
  );

  aat_add_tree #(
    .COORD_BITS   (COORD_BITS),
    .FRACTION_BITS(FRACTION_BITS),
    .SUM_W        (SUM_W)
  ) u_add_tree (
    .clk    (clk),
    .en     (add_en),
    .p_lo   (p_lo),
    .p_hi   (p_hi),
    .trans  (trans),
    .sum_lo (sum_lo),
    .sum_hi (sum_hi)
  );

  aat_sat #(
    .COORD_BITS   (COORD_BITS),
    .FRACTION_BITS(FRACTION_BITS),
    .SUM_W        (SUM_W)
  ) u_sat (
    .clk    (clk),
    .en     (rdy[4]),
    .sum_lo (sum_lo),
    .sum_hi (sum_hi),
    .out_lo (out_lo),
    .out_hi (out_hi)
  );

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      out_tdata[r*FIELD_W +: FIELD_W]            = out_lo[r];
      out_tdata[(NUM_ROWS+r)*FIELD_W +: FIELD_W] = out_hi[r];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `AAT_ASSERT_RST(a_rst_flush, rst |=> (!out_tvalid && in_tready), "reset left a word in the pipe")
  `AAT_ASSERT(a_full_stall, ((&vld) && !out_tready) |-> !in_tready, "input taken with pipe full")
  `AAT_ASSERT(a_out_src, $rose(out_tvalid) |-> $past(vld[STAGES-2]), "output word from nowhere")

  for (genvar g = 0; g < 2 * NUM_ROWS; g++) begin : g_range
    `AAT_ASSERT(a_out_range, out_tvalid |-> ((out_tdata[g*FIELD_W+COORD_BITS-1 +: FIELD_W-COORD_BITS+1] == '0) || (out_tdata[g*FIELD_W+COORD_BITS-1 +: FIELD_W-COORD_BITS+1] == '1)), "output bound outside coordinate range")
  end

endmodule
